@@ src/png_scanline_unfilter_defines.svh @@
// Assertion macros shared by the scanline unfilter RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define PSU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PSU_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/psu_pkg.sv @@
// Package for the scanline unfilter: widths, register and filter codes,
// the command passed from front to back, and the Paeth predictor.
`timescale 1ns / 1ps

package psu_pkg;

    localparam int PSU_MAX_ROW_BYTES   = 32768;
    localparam int PSU_MAX_PIXEL_BYTES = 8;

    localparam int ROW_BYTES_W   = 16;
    localparam int PIXEL_BYTES_W = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 1;

    // Widest column index and slot over the legal parameter range
    localparam int PSU_COL_W  = 18;
    localparam int PSU_SLOT_W = 3;

    localparam int PSU_QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_BYTES   = 1'b0,
        REG_PIXEL_BYTES = 1'b1
    } cfg_reg_t;

    localparam logic [7:0] FILT_NONE  = 8'd0;
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    typedef struct packed {
        logic [7:0]            filtered_byte;
        logic [7:0]            filter_kind;
        logic                  bad;
        logic                  first;
        logic                  has_left;
        logic                  last;
        logic [PSU_COL_W-1:0]  col;
        logic [PSU_SLOT_W-1:0] slot;
    } psu_cmd_t;

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        logic [7:0]        res;
        // p - a = b - c, p - b = a - c, p - c = a + b - 2c
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if ((pa <= pb) && (pa <= pc))
        begin
            res = a;
        end
        else if (pb <= pc)
        begin
            res = b;
        end
        else
        begin
            res = c;
        end
        return res;
    endfunction

endpackage

@@ src/psu_if.sv @@
// Valid/ready channel interfaces for filtered input and reconstructed output.
// No dependencies.
`timescale 1ns / 1ps

interface psu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] filtered_byte;
    logic [7:0] filter_kind;
    logic       image_start;

    modport source (output valid, filtered_byte, filter_kind, image_start, input ready);
    modport sink   (input valid, filtered_byte, filter_kind, image_start, output ready);
endinterface

interface psu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] recon_byte;
    logic       bad_filter;
    logic       row_end;

    modport source (output valid, recon_byte, bad_filter, row_end, input ready);
    modport sink   (input valid, recon_byte, bad_filter, row_end, output ready);
endinterface

@@ src/psu_queue.sv @@
// Short command queue between the front and back of the unfilter.
// Depends on psu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "png_scanline_unfilter_defines.svh"

module psu_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  psu_pkg::psu_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output psu_pkg::psu_cmd_t head
);
    import psu_pkg::*;

    localparam int PW = (PSU_QUEUE_DEPTH > 1) ? $clog2(PSU_QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(PSU_QUEUE_DEPTH + 1);

    psu_cmd_t        slot_mem_reg [PSU_QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [NW-1:0]   count_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_next;
    logic [NW-1:0]   count_next;

    assign full       = (count_reg == NW'(PSU_QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(PSU_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(PSU_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PSU_ASSERT_ALWAYS(a_queue_bound, count_reg <= NW'(PSU_QUEUE_DEPTH), "queue overrun")

endmodule

@@ src/psu_front.sv @@
// Front of the unfilter: configuration registers, column/slot tracking and
// command classification. Depends on psu_pkg, psu_if and the macro header.
`timescale 1ns / 1ps
`include "png_scanline_unfilter_defines.svh"

module psu_front #(
    parameter int MAX_ROW_BYTES   = psu_pkg::PSU_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = psu_pkg::PSU_MAX_PIXEL_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [psu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data,
    psu_in_if.sink                           filt,
    input  logic                             q_full,
    output logic                             q_push,
    output psu_pkg::psu_cmd_t                q_data
);
    import psu_pkg::*;

    localparam int CW   = $clog2(MAX_ROW_BYTES);
    localparam int SW   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int NW   = $clog2(CW);
    localparam int CMPW = (CW > PIXEL_BYTES_W) ? CW : PIXEL_BYTES_W;
    localparam int EW   = (CW + 1 > ROW_BYTES_W) ? CW + 1 : ROW_BYTES_W;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_PREP = 3'b010,
        ST_DIV  = 3'b100
    } front_state_t;

    front_state_t               state_reg, state_next;
    logic [ROW_BYTES_W-1:0]     row_bytes_reg, row_bytes_next;
    logic [PIXEL_BYTES_W-1:0]   pixel_bytes_reg, pixel_bytes_next;
    logic [CW-1:0]              rb_last_reg, rb_last_next;
    logic [PIXEL_BYTES_W-1:0]   pb_eff_reg, pb_eff_next;
    logic [CW-1:0]              col_reg, col_next;
    logic [SW-1:0]              slot_reg, slot_next;
    logic [SW-1:0]              last_slot_reg, last_slot_next;
    logic                       first_row_reg, first_row_next;
    logic [CW-1:0]              sh_col_reg, sh_col_next;
    logic [CW-1:0]              sh_last_reg, sh_last_next;
    logic [2:0]                 rem_col_reg, rem_col_next;
    logic [2:0]                 rem_last_reg, rem_last_next;
    logic [NW-1:0]              cnt_reg, cnt_next;

    logic [EW-1:0]              rb_ext;
    logic [CW-1:0]              rb_last_c;
    logic [PIXEL_BYTES_W-1:0]   pb_eff_c;
    logic [3:0]                 t_col;
    logic [3:0]                 t_last;
    logic [2:0]                 rem_col_step;
    logic [2:0]                 rem_last_step;
    logic                       accept;
    logic [CW-1:0]              col_raw;
    logic                       clamp;
    logic [CW-1:0]              col_c;
    logic [SW-1:0]              slot_c;
    logic                       first_c;
    logic                       last_c;
    logic                       has_left_c;

    assign filt.ready = (state_reg == ST_RUN) && !q_full;
    assign accept     = filt.valid && filt.ready;

    // Effective register values after the zero and saturation rules
    always_comb
    begin
        rb_ext = EW'(row_bytes_reg);
        if (rb_ext == '0)
        begin
            rb_last_c = '0;
        end
        else if (rb_ext > EW'(MAX_ROW_BYTES))
        begin
            rb_last_c = CW'(MAX_ROW_BYTES - 1);
        end
        else
        begin
            rb_last_c = CW'(rb_ext - 1'b1);
        end
        if (pixel_bytes_reg == '0)
        begin
            pb_eff_c = PIXEL_BYTES_W'(1);
        end
        else if (pixel_bytes_reg > PIXEL_BYTES_W'(MAX_PIXEL_BYTES))
        begin
            pb_eff_c = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
        end
        else
        begin
            pb_eff_c = pixel_bytes_reg;
        end
    end

    // One restoring remainder step for column position and last column
    always_comb
    begin
        t_col  = {rem_col_reg, sh_col_reg[CW-1]};
        t_last = {rem_last_reg, sh_last_reg[CW-1]};
        rem_col_step  = (t_col >= pb_eff_reg) ? 3'(t_col - pb_eff_reg) : t_col[2:0];
        rem_last_step = (t_last >= pb_eff_reg) ? 3'(t_last - pb_eff_reg) : t_last[2:0];
    end

    // Classification of the incoming byte
    always_comb
    begin
        col_raw    = filt.image_start ? '0 : col_reg;
        first_c    = filt.image_start ? 1'b1 : first_row_reg;
        clamp      = (col_raw > rb_last_reg);
        col_c      = clamp ? rb_last_reg : col_raw;
        slot_c     = filt.image_start ? '0 : (clamp ? last_slot_reg : slot_reg);
        last_c     = (col_c == rb_last_reg);
        has_left_c = (CMPW'(col_c) >= CMPW'(pb_eff_reg));

        q_push                 = accept;
        q_data.filtered_byte   = filt.filtered_byte;
        q_data.filter_kind     = filt.filter_kind;
        q_data.bad             = (filt.filter_kind > FILT_PAETH);
        q_data.first           = first_c;
        q_data.has_left        = has_left_c;
        q_data.last            = last_c;
        q_data.col             = PSU_COL_W'(col_c);
        q_data.slot            = PSU_SLOT_W'(slot_c);
    end

    always_comb
    begin
        state_next       = state_reg;
        row_bytes_next   = row_bytes_reg;
        pixel_bytes_next = pixel_bytes_reg;
        rb_last_next     = rb_last_reg;
        pb_eff_next      = pb_eff_reg;
        col_next         = col_reg;
        slot_next        = slot_reg;
        last_slot_next   = last_slot_reg;
        first_row_next   = first_row_reg;
        sh_col_next      = sh_col_reg;
        sh_last_next     = sh_last_reg;
        rem_col_next     = rem_col_reg;
        rem_last_next    = rem_last_reg;
        cnt_next         = cnt_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (last_c)
                    begin
                        col_next       = '0;
                        slot_next      = '0;
                        first_row_next = 1'b0;
                    end
                    else
                    begin
                        col_next       = col_c + 1'b1;
                        slot_next      = (PIXEL_BYTES_W'(slot_c) == pb_eff_reg - 1'b1) ?
                                         '0 : slot_c + 1'b1;
                        first_row_next = first_c;
                    end
                end
            end
            ST_PREP:
            begin
                rb_last_next  = rb_last_c;
                pb_eff_next   = pb_eff_c;
                sh_col_next   = col_reg;
                sh_last_next  = rb_last_c;
                rem_col_next  = '0;
                rem_last_next = '0;
                cnt_next      = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                sh_col_next   = {sh_col_reg[CW-2:0], 1'b0};
                sh_last_next  = {sh_last_reg[CW-2:0], 1'b0};
                rem_col_next  = rem_col_step;
                rem_last_next = rem_last_step;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == NW'(CW - 1))
                begin
                    slot_next      = SW'(rem_col_step);
                    last_slot_next = SW'(rem_last_step);
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW_BYTES:   row_bytes_next   = cfg_data[ROW_BYTES_W-1:0];
                REG_PIXEL_BYTES: pixel_bytes_next = cfg_data[PIXEL_BYTES_W-1:0];
                default:         ;
            endcase
            state_next = ST_PREP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            row_bytes_reg   <= ROW_BYTES_W'(1);
            pixel_bytes_reg <= PIXEL_BYTES_W'(1);
            rb_last_reg     <= '0;
            pb_eff_reg      <= PIXEL_BYTES_W'(1);
            col_reg         <= '0;
            slot_reg        <= '0;
            last_slot_reg   <= '0;
            first_row_reg   <= 1'b1;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            row_bytes_reg   <= row_bytes_next;
            pixel_bytes_reg <= pixel_bytes_next;
            rb_last_reg     <= rb_last_next;
            pb_eff_reg      <= pb_eff_next;
            col_reg         <= col_next;
            slot_reg        <= slot_next;
            last_slot_reg   <= last_slot_next;
            first_row_reg   <= first_row_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_col_reg   <= sh_col_next;
        sh_last_reg  <= sh_last_next;
        rem_col_reg  <= rem_col_next;
        rem_last_reg <= rem_last_next;
    end

    `PSU_ASSERT_IMPLY(a_no_accept_in_recalc, state_reg != ST_RUN, !filt.ready,
                      "input accepted during slot recalculation")
    `PSU_ASSERT_IMPLY(a_slot_in_pixel, state_reg == ST_RUN,
                      (PIXEL_BYTES_W'(slot_reg) < pb_eff_reg) &&
                      (PIXEL_BYTES_W'(last_slot_reg) < pb_eff_reg),
                      "slot outside pixel")

endmodule

@@ src/psu_back.sv @@
// Back of the unfilter: line store, left/up-left history, prediction and
// output register. Depends on psu_pkg, psu_if and the macro header.
`timescale 1ns / 1ps
`include "png_scanline_unfilter_defines.svh"

module psu_back #(
    parameter int MAX_ROW_BYTES   = psu_pkg::PSU_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = psu_pkg::PSU_MAX_PIXEL_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  psu_pkg::psu_cmd_t q_head,
    output logic              q_pop,
    psu_out_if.source         recon
);
    import psu_pkg::*;

    localparam int CW = $clog2(MAX_ROW_BYTES);
    localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic [7:0]    line_mem [MAX_ROW_BYTES];
    logic [7:0]    left_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0]    up_hist_reg [MAX_PIXEL_BYTES];

    logic          b2_valid_reg, b2_valid_next;
    psu_cmd_t      b2_cmd_reg;
    logic          fwd_reg;
    logic [7:0]    fwd_byte_reg;
    logic [7:0]    rd_byte_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_bad_reg;
    logic          out_last_reg;

    logic          fire;
    logic          load;
    logic [CW-1:0] wr_col;
    logic [CW-1:0] rd_col;
    logic [SW-1:0] slot;
    logic [7:0]    above;
    logic [7:0]    left;
    logic [7:0]    upleft;
    logic [8:0]    avg_sum;
    logic [7:0]    pred;
    logic [7:0]    recon_c;

    assign fire   = b2_valid_reg && (!out_valid_reg || recon.ready);
    assign load   = q_valid && (!b2_valid_reg || fire);
    assign q_pop  = load;
    assign wr_col = b2_cmd_reg.col[CW-1:0];
    assign rd_col = q_head.col[CW-1:0];
    assign slot   = b2_cmd_reg.slot[SW-1:0];

    always_comb
    begin
        above   = b2_cmd_reg.first ? 8'd0 : (fwd_reg ? fwd_byte_reg : rd_byte_reg);
        left    = b2_cmd_reg.has_left ? left_hist_reg[slot] : 8'd0;
        upleft  = (b2_cmd_reg.has_left && !b2_cmd_reg.first) ? up_hist_reg[slot] : 8'd0;
        avg_sum = {1'b0, left} + {1'b0, above};
        case (b2_cmd_reg.filter_kind)
            FILT_NONE: pred = 8'd0;
            FILT_SUB:  pred = left;
            FILT_UP:   pred = above;
            FILT_AVG:  pred = avg_sum[8:1];
            default:   pred = paeth_pred(left, above, upleft);
        endcase
        recon_c = b2_cmd_reg.bad ? 8'd0 : b2_cmd_reg.filtered_byte + pred;
    end

    always_comb
    begin
        b2_valid_next = b2_valid_reg;
        if (load)
        begin
            b2_valid_next = 1'b1;
        end
        else if (fire)
        begin
            b2_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (recon.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i] <= 8'd0;
                up_hist_reg[i]   <= 8'd0;
            end
        end
        else
        begin
            b2_valid_reg  <= b2_valid_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                // Row of one column: the byte just finished is the one above
                fwd_reg <= fire && (wr_col == rd_col);
            end
            else if (fire)
            begin
                fwd_reg <= 1'b0;
            end
            if (fire)
            begin
                left_hist_reg[slot] <= recon_c;
                up_hist_reg[slot]   <= above;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b2_cmd_reg   <= q_head;
            fwd_byte_reg <= recon_c;
        end
        if (fire)
        begin
            out_byte_reg <= recon_c;
            out_bad_reg  <= b2_cmd_reg.bad;
            out_last_reg <= b2_cmd_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            line_mem[wr_col] <= recon_c;
        end
        if (load)
        begin
            rd_byte_reg <= line_mem[rd_col];
        end
    end

    assign recon.valid      = out_valid_reg;
    assign recon.recon_byte = out_byte_reg;
    assign recon.bad_filter = out_bad_reg;
    assign recon.row_end    = out_last_reg;

    `PSU_ASSERT_IMPLY(a_fwd_needs_item, fwd_reg, b2_valid_reg, "bypass flag without item")

endmodule

@@ src/png_scanline_unfilter.sv @@
// PNG scanline unfilter, top level.
// Channel filt (valid/ready) carries one filtered byte per transaction with
// its row filter type and an image-start mark; channel recon returns one
// reconstructed byte per transaction with bad-filter and row-end flags.
// Results leave in input order, one per input transaction.
// Throughput: one byte per cycle while recon is ready and no configuration
// write is in progress; the bound is the single port pair of the line store,
// read when a command enters the back stage, written when it leaves.
// Configuration: cfg_we/cfg_index/cfg_data write row_bytes (index 0) or
// pixel_bytes (index 1). Each write starts a bit-serial remainder that
// re-derives the pixel slot; filt.ready stays low while it runs (ST_PREP, ST_DIV).
// Reset: row_bytes = 1, pixel_bytes = 1, column 0, first row, histories zero;
// the line store is not cleared and its contents are ignored for the first row.
// Stall: a held-off receiver fills the output register, back stage and a
// four-entry queue, after which filt.ready drops; nothing is lost.
// Depends on psu_pkg, psu_if, psu_queue, psu_front and psu_back.
`timescale 1ns / 1ps

module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = psu_pkg::PSU_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = psu_pkg::PSU_MAX_PIXEL_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    psu_in_if.sink                          filt,
    psu_out_if.source                       recon,
    input  logic                            cfg_we,
    input  logic [psu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import psu_pkg::*;

    logic     q_push;
    logic     q_full;
    psu_cmd_t q_data;
    logic     q_pop;
    logic     q_valid;
    psu_cmd_t q_head;

    psu_front #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .filt      (filt),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    psu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    psu_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .recon   (recon)
    );

endmodule
